// File: sv/circular_queue_with_search_macros.svh
// ----------------------------------------------------------------------------
// circular queue with search: assertion macros
// concurrent check helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

`define CQS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

`define CQS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define CQS_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define CQS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/cqs_pkg.sv
// ----------------------------------------------------------------------------
// cqs_pkg
// shared types, constants and helpers of the circular queue with search
// ----------------------------------------------------------------------------
`default_nettype none

package cqs_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int IDX_W  = 4;
    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [PTR_W-1:0]         t_ptr;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_MISS  = 2'd3
    } t_status;

    typedef struct packed {
        logic  we;
        t_ptr  waddr;
        t_word wdata;
        t_ptr  raddr;
    } t_mem_req;

    function automatic t_ptr next_slot(input t_ptr p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : t_ptr'(p + 1'b1);
    endfunction

    function automatic logic is_full(input t_ptr head, input t_ptr tail,
                                     input logic empty);
        return !empty && (next_slot(tail) == head);
    endfunction

endpackage

`default_nettype wire

// File: sv/circular_queue_with_search.sv
// ----------------------------------------------------------------------------
// circular_queue_with_search
// ring-buffer queue of signed words with push, pop, peek and slot search
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// word appears in the cycle after the work ends, for exactly one cycle, marked
// by o_done, and cannot be held off. Push, pop and peek read the slot memory;
// push and pop then update it. Search walks the slots through one comparator,
// one slot per cycle from slot 0, and stops early on a match. busy is low again in
// the cycle that o_done is high, so the next command may be issued there.
`default_nettype none

`include "circular_queue_with_search_macros.svh"

module circular_queue_with_search (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic signed [cqs_pkg::WORD_W-1:0] i_value_in,
    output logic                                   o_done,
    output logic signed [cqs_pkg::WORD_W-1:0]      o_data_out,
    output logic [1:0]                             o_status,
    output logic [cqs_pkg::IDX_W-1:0]              o_found_index,
    output logic [cqs_pkg::IDX_W-1:0]              o_head_index,
    output logic [cqs_pkg::IDX_W-1:0]              o_tail_index,
    output logic                                   o_is_empty,
    output logic                                   o_is_full
);

    cqs_pkg::t_mem_req mem_req;
    cqs_pkg::t_word    mem_rdata;

    cqs_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    cqs_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_opcode      (i_opcode),
        .i_value_in    (i_value_in),
        .i_rdata       (mem_rdata),
        .o_req         (mem_req),
        .o_busy        (busy),
        .o_done        (o_done),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_head_index  (o_head_index),
        .o_tail_index  (o_tail_index),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    `CQS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `CQS_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `CQS_ASSERT_IMP(a_empty_ptrs, i_clk, i_rst_n, o_done && o_is_empty,
                    o_head_index == '0 && o_tail_index == '0)
    `CQS_ASSERT_IMP(a_full_not_empty, i_clk, i_rst_n, o_is_full, !o_is_empty)
    `CQS_ASSERT_IMP(a_empty_no_data, i_clk, i_rst_n,
                    o_done && o_status == cqs_pkg::STAT_EMPTY, o_data_out == '0)

endmodule

`default_nettype wire

// File: sv/cqs_store.sv
// ----------------------------------------------------------------------------
// cqs_store
// slot memory, one write and one registered read port, zero until written
// ----------------------------------------------------------------------------
`default_nettype none

module cqs_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cqs_pkg::t_mem_req i_req,
    output cqs_pkg::t_word         o_rdata
);

    cqs_pkg::t_word                 r_mem [cqs_pkg::DEPTH];
    logic [cqs_pkg::DEPTH-1:0]      r_vld;
    cqs_pkg::t_word                 r_rdata;
    logic                           r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    // written flags, unwritten slots read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_req.raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

// File: sv/cqs_seq.sv
// ----------------------------------------------------------------------------
// cqs_seq
// sequencer with the search word comparator, pointer and flag state
// ----------------------------------------------------------------------------
`default_nettype none

module cqs_seq (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [1:0]                     i_opcode,
    input  wire logic signed [cqs_pkg::WORD_W-1:0] i_value_in,
    input  wire cqs_pkg::t_word                 i_rdata,
    output cqs_pkg::t_mem_req                   o_req,
    output logic                                o_busy,
    output logic                                o_done,
    output logic signed [cqs_pkg::WORD_W-1:0]   o_data_out,
    output logic [1:0]                          o_status,
    output logic [cqs_pkg::IDX_W-1:0]           o_found_index,
    output logic [cqs_pkg::IDX_W-1:0]           o_head_index,
    output logic [cqs_pkg::IDX_W-1:0]           o_tail_index,
    output logic                                o_is_empty,
    output logic                                o_is_full
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                r_state, n_state;
    cqs_pkg::t_op          r_op, n_op;
    cqs_pkg::t_word        r_val, n_val;
    cqs_pkg::t_ptr         r_head, n_head;
    cqs_pkg::t_ptr         r_tail, n_tail;
    logic                  r_empty, n_empty;
    cqs_pkg::t_ptr         r_idx, n_idx;
    logic                  r_done, n_done;
    cqs_pkg::t_word        r_data, n_data;
    cqs_pkg::t_status      r_status, n_status;
    cqs_pkg::t_ptr         r_found, n_found;
    logic                  hit;

    // search comparator
    assign hit = (i_rdata == r_val);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_val    = r_val;
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_idx    = r_idx;
        n_done   = 1'b0;
        n_data   = r_data;
        n_status = r_status;
        n_found  = r_found;
        o_req.we    = 1'b0;
        o_req.waddr = r_head;
        o_req.wdata = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = cqs_pkg::t_op'(i_opcode);
                    n_val   = i_value_in;
                    n_state = S_EXEC;
                    n_idx   = (cqs_pkg::t_op'(i_opcode) == cqs_pkg::OP_SEARCH) ? '0 : r_head;
                end
            end
            S_EXEC: begin
                n_data   = '0;
                n_status = cqs_pkg::STAT_OK;
                n_found  = '0;
                n_done   = 1'b1;
                n_state  = S_IDLE;
                unique case (r_op)
                    cqs_pkg::OP_PUSH: begin
                        if (r_empty) begin
                            n_head      = '0;
                            n_tail      = '0;
                            n_empty     = 1'b0;
                            o_req.we    = 1'b1;
                            o_req.waddr = '0;
                            o_req.wdata = r_val;
                        end else if (cqs_pkg::is_full(r_head, r_tail, r_empty)) begin
                            n_status = cqs_pkg::STAT_FULL;
                        end else begin
                            n_tail      = cqs_pkg::next_slot(r_tail);
                            o_req.we    = 1'b1;
                            o_req.waddr = cqs_pkg::next_slot(r_tail);
                            o_req.wdata = r_val;
                        end
                    end
                    cqs_pkg::OP_POP: begin
                        if (r_empty) begin
                            n_status = cqs_pkg::STAT_EMPTY;
                        end else begin
                            n_data      = i_rdata;
                            o_req.we    = 1'b1;
                            o_req.waddr = r_head;
                            if (r_head == r_tail) begin
                                n_head  = '0;
                                n_tail  = '0;
                                n_empty = 1'b1;
                            end else begin
                                n_head = cqs_pkg::next_slot(r_head);
                            end
                        end
                    end
                    cqs_pkg::OP_PEEK: begin
                        if (r_empty) begin
                            n_status = cqs_pkg::STAT_EMPTY;
                        end else begin
                            n_data = i_rdata;
                        end
                    end
                    cqs_pkg::OP_SEARCH: begin
                        priority if (hit) begin
                            n_found = r_idx;
                        end else if (r_idx == cqs_pkg::PTR_W'(cqs_pkg::DEPTH - 1)) begin
                            n_status = cqs_pkg::STAT_MISS;
                        end else begin
                            // next slot, one compare per cycle
                            n_idx   = cqs_pkg::t_ptr'(r_idx + 1'b1);
                            n_done  = 1'b0;
                            n_state = S_EXEC;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_req.raddr = n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_done  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            r_done  <= n_done;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_data   <= n_data;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_data_out    = r_data;
    assign o_status      = r_status;
    assign o_found_index = cqs_pkg::IDX_W'(r_found);
    assign o_head_index  = cqs_pkg::IDX_W'(r_head);
    assign o_tail_index  = cqs_pkg::IDX_W'(r_tail);
    assign o_is_empty    = r_empty;
    assign o_is_full     = cqs_pkg::is_full(r_head, r_tail, r_empty);

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: circular queue with search
// drives push, pop, peek and search commands through the start/busy
// handshake, first from a directed table, then as random fill and drain
// runs under several sender idle rates; every word on o_done is checked
// field by field against the table reply or else a ring-buffer predictor kept in the bench
// ----------------------------------------------------------------------------
module tb_top;
    import cqs_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 144;
    localparam int FILL_PUSHES  = 13;

    typedef struct packed {
        t_word              data;
        t_status            status;
        logic [IDX_W-1:0]   found;
        logic [IDX_W-1:0]   head;
        logic [IDX_W-1:0]   tail;
        logic               empty;
        logic               full;
    } t_reply;

    typedef struct {
        t_op    op;
        t_word  val;
        bit     typed;
        t_reply reply;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         i_opcode = '0;
    t_word              i_value_in = '0;
    logic               busy;
    logic               o_done;
    t_word              o_data_out;
    logic [1:0]         o_status;
    logic [IDX_W-1:0]   o_found_index;
    logic [IDX_W-1:0]   o_head_index;
    logic [IDX_W-1:0]   o_tail_index;
    logic               o_is_empty;
    logic               o_is_full;

    t_word  ring_slots [DEPTH];
    t_ptr   ring_head;
    t_ptr   ring_tail;
    logic   ring_empty;

    t_reply pending_replies [$];
    t_row   stim_table [$];
    t_reply got_reply;
    t_reply want_reply;
    int     mismatches = 0;
    int     quiet_cycles = 0;

    circular_queue_with_search uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_value_in    (i_value_in),
        .o_done        (o_done),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_head_index  (o_head_index),
        .o_tail_index  (o_tail_index),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic ring_is_full();
        int occ;
        if (ring_empty) begin
            return 1'b0;
        end
        occ = (int'(ring_tail) - int'(ring_head) + DEPTH) % DEPTH + 1;
        return occ == DEPTH;
    endfunction

    function automatic t_reply ring_op_reply(input t_op op, input t_word val);
        t_reply r;
        r = '0;
        case (op)
            OP_PUSH: begin
                if (ring_empty) begin
                    ring_head = '0;
                    ring_tail = '0;
                    ring_slots[0] = val;
                    ring_empty = 1'b0;
                end else if (ring_is_full()) begin
                    r.status = STAT_FULL;
                end else begin
                    ring_tail = t_ptr'((int'(ring_tail) + 1) % DEPTH);
                    ring_slots[ring_tail] = val;
                end
            end
            OP_POP: begin
                if (ring_empty) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.data = ring_slots[ring_head];
                    ring_slots[ring_head] = '0;
                    if (ring_head == ring_tail) begin
                        ring_head = '0;
                        ring_tail = '0;
                        ring_empty = 1'b1;
                    end else begin
                        ring_head = t_ptr'((int'(ring_head) + 1) % DEPTH);
                    end
                end
            end
            OP_PEEK: begin
                if (ring_empty) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.data = ring_slots[ring_head];
                end
            end
            default: begin
                r.status = STAT_MISS;
                for (int k = DEPTH - 1; k >= 0; k--) begin
                    if (ring_slots[k] == val) begin
                        r.status = STAT_OK;
                        r.found = IDX_W'(k);
                    end
                end
            end
        endcase
        r.head = IDX_W'(ring_head);
        r.tail = IDX_W'(ring_tail);
        r.empty = ring_empty;
        r.full = ring_is_full();
        return r;
    endfunction

    function automatic t_row plain_row(input t_op op, input t_word val);
        t_row row;
        row.op = op;
        row.val = val;
        row.typed = 1'b0;
        row.reply = '0;
        return row;
    endfunction

    function automatic t_row typed_row(input t_op op, input t_word val, input t_reply reply);
        t_row row;
        row = plain_row(op, val);
        row.typed = 1'b1;
        row.reply = reply;
        return row;
    endfunction

    function automatic t_word pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 32'sh8000_0000;
            2:       return 32'sh7fff_ffff;
            3:       return -32'sd1;
            4, 5:    return t_word'($urandom_range(15));
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_op pick_op(input bit draining);
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            return OP_SEARCH;
        end else if (roll < 25) begin
            return OP_PEEK;
        end else if (roll < (draining ? 70 : 45)) begin
            return OP_POP;
        end
        return OP_PUSH;
    endfunction

    task automatic send_word(input t_op op, input t_word val, input bit typed,
                             input t_reply reply);
        t_reply predicted;
        i_opcode <= op;
        i_value_in <= val;
        start <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        predicted = ring_op_reply(op, val);
        pending_replies.push_back(typed ? reply : predicted);
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        while (pending_replies.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top failed");
            $finish;
        end
        if (i_rst_n && o_done) begin
            got_reply = '{o_data_out, t_status'(o_status), o_found_index, o_head_index,
                          o_tail_index, o_is_empty, o_is_full};
            if (pending_replies.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word data=%0d status=%0d", $time,
                         o_data_out, o_status);
            end else begin
                want_reply = pending_replies.pop_front();
                if (got_reply !== want_reply) begin
                    mismatches++;
                    $display("%0t: expected data=%0d status=%0d found=%0d head=%0d tail=%0d empty=%0b full=%0b",
                             $time, want_reply.data, want_reply.status, want_reply.found,
                             want_reply.head, want_reply.tail, want_reply.empty,
                             want_reply.full);
                    $display("%0t: actual   data=%0d status=%0d found=%0d head=%0d tail=%0d empty=%0b full=%0b",
                             $time, got_reply.data, got_reply.status, got_reply.found,
                             got_reply.head, got_reply.tail, got_reply.empty,
                             got_reply.full);
                end
            end
        end
    end

    initial begin
        int idle_rates [4];
        int gap;
        bit draining;
        t_op op;
        t_word val;

        idle_rates = '{0, 79, 0, 27};
        draining = 1'b0;
        foreach (ring_slots[k]) begin
            ring_slots[k] = '0;
        end
        ring_head = '0;
        ring_tail = '0;
        ring_empty = 1'b1;

        stim_table.push_back(typed_row(OP_POP, 32'sd5,
                             '{'0, STAT_EMPTY, 4'd0, 4'd0, 4'd0, 1'b1, 1'b0}));
        stim_table.push_back(typed_row(OP_PEEK, -32'sd1,
                             '{'0, STAT_EMPTY, 4'd0, 4'd0, 4'd0, 1'b1, 1'b0}));
        stim_table.push_back(typed_row(OP_SEARCH, 32'sd0,
                             '{'0, STAT_OK, 4'd0, 4'd0, 4'd0, 1'b1, 1'b0}));
        stim_table.push_back(typed_row(OP_SEARCH, 32'sh7fff_ffff,
                             '{'0, STAT_MISS, 4'd0, 4'd0, 4'd0, 1'b1, 1'b0}));
        stim_table.push_back(typed_row(OP_PUSH, 32'sh8000_0000,
                             '{'0, STAT_OK, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0}));
        stim_table.push_back(plain_row(OP_PUSH, 32'sh7fff_ffff));
        stim_table.push_back(plain_row(OP_PUSH, -32'sd1));
        for (int k = 0; k < FILL_PUSHES; k++) begin
            stim_table.push_back(plain_row(OP_PUSH, t_word'(32'h1357_9bdf * (k + 1))));
        end
        stim_table.push_back(typed_row(OP_PUSH, 32'sd77,
                             '{'0, STAT_FULL, 4'd0, 4'd0, 4'd15, 1'b0, 1'b1}));
        stim_table.push_back(plain_row(OP_POP, 32'sd0));
        stim_table.push_back(plain_row(OP_SEARCH, 32'sd0));
        stim_table.push_back(plain_row(OP_PUSH, 32'sh5555_aaaa));
        stim_table.push_back(plain_row(OP_SEARCH, -32'sd1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[k]) begin
            send_word(stim_table[k].op, stim_table[k].val, stim_table[k].typed,
                      stim_table[k].reply);
        end
        drain_replies();

        foreach (idle_rates[p]) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                gap = 0;
                while ($urandom_range(99) < idle_rates[p] && gap < 60) begin
                    gap++;
                end
                if (gap != 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                if (ring_is_full()) begin
                    draining = 1'b1;
                end else if (ring_empty) begin
                    draining = 1'b0;
                end else if ($urandom_range(49) == 0) begin
                    draining = ~draining;
                end
                op = pick_op(draining);
                if (op == OP_SEARCH && $urandom_range(1) == 1) begin
                    val = ring_slots[$urandom_range(DEPTH - 1)];
                end else begin
                    val = pick_value();
                end
                send_word(op, val, 1'b0, '0);
            end
            drain_replies();
        end

        repeat (2 * DEPTH) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
